### hw/rtl/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

    // Fixed field widths of the channels.
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 4;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 16;
    localparam int TIME_W   = 32;
    localparam int CLOCK_W  = 64;
    localparam int STATUS_W = 2;

    localparam int NUM_TASKS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_EDIT    = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_STOP    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNTED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ONCE    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIRED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                latch;
        logic                advance;
        logic                delete_slot;
        logic                edit_wr;
        logic                clear_idx;
        logic                inc_idx;
        logic                add_wr;
        logic                mem_rd;
        logic                eval;
        logic                fire_wr;
        logic                emit;
        logic [STATUS_W-1:0] emit_st;
        logic                emit_idx;
    } ptt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idx_end;
        logic            idx_free;
        logic            fire;
        logic            out_free;
    } ptt_sts_t;

endpackage

`default_nettype wire

### hw/rtl/ptt_req_if.sv
`default_nettype none

interface ptt_req_if import ptt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] slot;
    logic [MODE_W-1:0] task_mode;
    logic [COUNT_W-1:0] run_count;
    logic [TIME_W-1:0] interval_ms;
    logic [TIME_W-1:0] advance_ms;

    modport source (
        output valid, opcode, slot, task_mode, run_count, interval_ms, advance_ms,
        input  ready
    );

    modport sink (
        input  valid, opcode, slot, task_mode, run_count, interval_ms, advance_ms,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/ptt_rsp_if.sv
`default_nettype none

interface ptt_rsp_if import ptt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic [COUNT_W-1:0]  count_left;
    logic                last;

    modport source (
        output valid, status, result_slot, count_left, last,
        input  ready
    );

    modport sink (
        input  valid, status, result_slot, count_left, last,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/periodic_task_timer_table.sv
`default_nettype none

// Periodic task timer table: a 64-bit millisecond clock and NUM_TASKS task slots, driven
// by request words (advance, add, delete, edit, scan) and answered by result words, the
// final one of each request flagged by last. Advance, delete, edit and unknown opcodes
// go from decode straight to the emit state for their acknowledge. An add searches the
// used flags one slot per cycle until it finds a free slot or reaches the end. A scan
// takes each slot through memory read, due check, and write-back with fire word, because
// slot data sits in a table with a registered read; a fire word may wait for the output
// to drain. One request is handled at a time; the next is taken as soon as the previous
// closing word sits in the output register.
// The slot table needs no clearing after reset: only the used flags are reset.
module periodic_task_timer_table import ptt_pkg::*;
#(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ptt_req_if.sink   req,
    ptt_rsp_if.source rsp
);

    ptt_cmd_t cmd;
    ptt_sts_t sts;
    logic     in_ready;

    assign req.ready = in_ready;

    ptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptt_datapath #(
        .NUM_TASKS  (NUM_TASKS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (req.opcode),
        .slot        (req.slot),
        .task_mode   (req.task_mode),
        .run_count   (req.run_count),
        .interval_ms (req.interval_ms),
        .advance_ms  (req.advance_ms),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

### hw/rtl/ptt_ctrl.sv
`default_nettype none

module ptt_ctrl import ptt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ptt_sts_t sts,
    output ptt_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_SRCH,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_SCAN_FIRE,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [STATUS_W-1:0] st_reg;
    logic                idx_sel_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd       = '0;
        cmd.latch = in_valid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    OP_ADVANCE: cmd.advance     = 1'b1;
                    OP_DELETE:  cmd.delete_slot = 1'b1;
                    OP_EDIT:    cmd.edit_wr     = 1'b1;
                    OP_ADD:     cmd.clear_idx   = 1'b1;
                    OP_SCAN:    cmd.clear_idx   = 1'b1;
                    default:
                    begin
                    end
                endcase
            end
            S_ADD_SRCH:
            begin
                if (!sts.idx_end)
                begin
                    if (sts.idx_free)
                        cmd.add_wr = 1'b1;
                    else
                        cmd.inc_idx = 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                cmd.mem_rd = !sts.idx_end;
            end
            S_SCAN_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            S_SCAN_FIRE:
            begin
                if (!sts.fire)
                    cmd.inc_idx = 1'b1;
                else if (sts.out_free)
                begin
                    cmd.fire_wr  = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.emit_st  = ST_FIRED;
                    cmd.emit_idx = 1'b1;
                    cmd.inc_idx  = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_st  = st_reg;
                    cmd.emit_idx = idx_sel_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            st_reg      <= ST_ACK;
            idx_sel_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    st_reg      <= ST_ACK;
                    idx_sel_reg <= 1'b0;
                    unique case (sts.op)
                        OP_ADD:  state_reg <= S_ADD_SRCH;
                        OP_SCAN: state_reg <= S_SCAN_RD;
                        default: state_reg <= S_EMIT;
                    endcase
                end
                S_ADD_SRCH:
                begin
                    if (sts.idx_end)
                    begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_EMIT;
                    end
                    else if (sts.idx_free)
                    begin
                        idx_sel_reg <= 1'b1;
                        state_reg   <= S_EMIT;
                    end
                end
                S_SCAN_RD:
                begin
                    if (sts.idx_end)
                    begin
                        st_reg    <= ST_DONE;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_SCAN_EVAL;
                end
                S_SCAN_EVAL:
                begin
                    state_reg <= S_SCAN_FIRE;
                end
                S_SCAN_FIRE:
                begin
                    if (!sts.fire || sts.out_free)
                        state_reg <= S_SCAN_RD;
                end
                S_EMIT:
                begin
                    if (sts.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ptt_datapath.sv
`default_nettype none

module ptt_datapath import ptt_pkg::*;
#(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptt_cmd_t           cmd,
    output ptt_sts_t                sts,
    input  wire logic [OP_W-1:0]    opcode,
    input  wire logic [SLOT_W-1:0]  slot,
    input  wire logic [MODE_W-1:0]  task_mode,
    input  wire logic [COUNT_W-1:0] run_count,
    input  wire logic [TIME_W-1:0]  interval_ms,
    input  wire logic [TIME_W-1:0]  advance_ms,
    ptt_rsp_if.source               rsp
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int RNG_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int IXS_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CX_W  = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [COUNT_BITS-1:0] count;
        logic [TIME_W-1:0]     interval;
        logic [CLOCK_W-1:0]    deadline;
    } entry_t;

    // Latched input word.
    logic [OP_W-1:0]       op_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [TIME_W-1:0]     interval_reg;
    logic [TIME_W-1:0]     adv_reg;

    logic [CLOCK_W-1:0]    clock_reg;
    logic [NUM_TASKS-1:0]  used_reg;
    logic [CNT_W-1:0]      idx_reg;

    entry_t                mem [NUM_TASKS];
    entry_t                rd_reg;

    logic                  fire_reg;
    logic [COUNT_BITS-1:0] cnt_new_reg;
    logic [CLOCK_W-1:0]    dl_new_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_last_reg;

    logic [IDX_W-1:0]      idx_i;
    logic [IDX_W-1:0]      slot_i;
    logic                  slot_ok;
    logic                  out_free;
    logic                  fire_now;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;
    logic [CLOCK_W-1:0]    arm_sum;
    logic [CLOCK_W-1:0]    rearm_sum;

    assign idx_i    = idx_reg[IDX_W-1:0];
    assign slot_i   = IDX_W'(IXS_W'(slot_reg));
    assign slot_ok  = RNG_W'(slot_reg) < RNG_W'(NUM_TASKS);
    assign out_free = !out_valid_reg || rsp.ready;

    assign arm_sum   = clock_reg + CLOCK_W'(interval_reg);
    assign rearm_sum = clock_reg + CLOCK_W'(rd_reg.interval);

    // A used, non-STOP slot (COUNTED: count>0) is due if deadline <= clock (64-bit).
    assign fire_now = used_reg[idx_i] && (rd_reg.mode != MODE_STOP)
                      && !((rd_reg.mode == MODE_COUNTED) && (rd_reg.count == '0))
                      && (rd_reg.deadline <= clock_reg);

    always_comb
    begin
        if (cmd.fire_wr)
        begin
            wr_en   = (rd_reg.mode != MODE_ONCE);
            wr_addr = idx_i;
            wr_data = '{mode: rd_reg.mode, count: cnt_new_reg,
                        interval: rd_reg.interval, deadline: dl_new_reg};
        end
        else
        begin
            wr_en   = cmd.add_wr || (cmd.edit_wr && slot_ok);
            wr_addr = cmd.edit_wr ? slot_i : idx_i;
            wr_data = '{mode: mode_reg, count: count_reg,
                        interval: interval_reg, deadline: arm_sum};
        end
    end

    assign sts.op       = op_reg;
    assign sts.idx_end  = (idx_reg == CNT_W'(NUM_TASKS));
    assign sts.idx_free = !used_reg[idx_i];
    assign sts.fire     = fire_reg;
    assign sts.out_free = out_free;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.result_slot = out_slot_reg;
    assign rsp.count_left  = out_count_reg;
    assign rsp.last        = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg       <= opcode;
            slot_reg     <= slot;
            mode_reg     <= task_mode;
            count_reg    <= COUNT_BITS'(CX_W'(run_count));
            interval_reg <= interval_ms;
            adv_reg      <= advance_ms;
        end
        if (cmd.mem_rd)
            rd_reg <= mem[idx_i];
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.eval)
        begin
            cnt_new_reg <= (rd_reg.mode == MODE_COUNTED) ? rd_reg.count - COUNT_BITS'(1)
                                                         : rd_reg.count;
            dl_new_reg  <= rearm_sum;
        end
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_st;
            out_slot_reg   <= cmd.emit_idx ? SLOT_W'(IXS_W'(idx_i)) : '0;
            out_count_reg  <= (cmd.emit_st == ST_FIRED) ? COUNT_W'(CX_W'(cnt_new_reg)) : '0;
            out_last_reg   <= (cmd.emit_st != ST_FIRED);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg     <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            fire_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.advance)
                clock_reg <= clock_reg + CLOCK_W'(adv_reg);
            if (cmd.add_wr)
                used_reg[idx_i] <= 1'b1;
            if (cmd.delete_slot && slot_ok)
                used_reg[slot_i] <= 1'b0;
            if (cmd.fire_wr && (rd_reg.mode == MODE_ONCE))
                used_reg[idx_i] <= 1'b0;
            if (cmd.clear_idx)
                idx_reg <= '0;
            else if (cmd.inc_idx)
                idx_reg <= idx_reg + CNT_W'(1);
            if (cmd.eval)
                fire_reg <= fire_now;
            else if (cmd.inc_idx)
                fire_reg <= 1'b0;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result word issued while output register is occupied");

    a_fire_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire_wr |-> fire_reg)
        else $error("slot write-back without a due slot");

    a_add_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_wr |=> used_reg[$past(idx_i)])
        else $error("added slot not marked used");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |=> clock_reg == $past(clock_reg) + CLOCK_W'($past(adv_reg)))
        else $error("clock did not advance by the requested amount");
`endif

endmodule

`default_nettype wire
